/* hdl/chre_pkg.sv */
package chre_pkg;

  localparam int SYMBOL_COUNT    = 260;
  localparam int SYM_W           = 9;
  localparam int LEN_W           = 5;
  localparam int CODE_W          = 16;
  localparam int ENTRY_W         = LEN_W + CODE_W;
  localparam int MAX_CODE_LENGTH = 16;
  localparam int RUN_LIMIT       = 257;
  localparam int MAX_OUT         = 8;

  localparam logic [2:0] A_START = 3'd0;
  localparam logic [2:0] A_LOAD  = 3'd1;
  localparam logic [2:0] A_BUILD = 3'd2;
  localparam logic [2:0] A_DATA  = 3'd3;
  localparam logic [2:0] A_END   = 3'd4;

  localparam logic [15:0]      MAGIC       = 16'h0100;
  localparam logic [4:0]       HDR_TAG_BASE = 5'h1c;
  localparam logic [SYM_W-1:0] REPEAT_BASE = 9'd256;
  localparam logic [SYM_W-1:0] END_SYMBOL  = 9'd259;

  typedef logic [1:0] cnt_class_t;

  function automatic cnt_class_t cnt_class(input logic [8:0] c);
    cnt_class_t r;
    if (c <= 9'd6) r = 2'd0;
    else if (c <= 9'd10) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

  function automatic logic [4:0] cnt_len(input cnt_class_t k);
    logic [4:0] r;
    unique case (k)
      2'd0: r = 5'd2;
      2'd1: r = 5'd3;
      default: r = 5'd8;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] cnt_bits(input logic [8:0] c);
    logic [8:0] d;
    logic [8:0] m;
    d = c - 9'd3;
    m = (9'd1 << cnt_len(cnt_class(c))) - 9'd1;
    return 16'(d & m);
  endfunction

endpackage

/* hdl/canonical_huffman_rle_encoder_core.sv */
// channel | dir | tdata                                  | tlast     | tuser
// s_      | in  | [2:0] action [7:3] code_length [15:8] data_byte | -  | -
// m_      | out | [7:0] out_byte                         | item_done | stream_done
// One item at a time. A data byte that extends a run only counts it; a run
// flush pushes each code and drains each byte before the next item is taken.
// Build scans the code memory once per level. Sync reset.
// Throughput is set by the single read port of the symbol memory and the
// one-byte-per-cycle packer drain while m_ is free; m_ stalls hold the packer.
module canonical_huffman_rle_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // action, code_length, data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // stream_done
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_FIN   = 5'd1;
  localparam logic [4:0] ST_HF0   = 5'd2;
  localparam logic [4:0] ST_HF1   = 5'd3;
  localparam logic [4:0] ST_HF2   = 5'd4;
  localparam logic [4:0] ST_LPOST = 5'd5;
  localparam logic [4:0] ST_DF0   = 5'd6;
  localparam logic [4:0] ST_DF1   = 5'd7;
  localparam logic [4:0] ST_DF2   = 5'd8;
  localparam logic [4:0] ST_DF3   = 5'd9;
  localparam logic [4:0] ST_DF4   = 5'd10;
  localparam logic [4:0] ST_DPOST = 5'd11;
  localparam logic [4:0] ST_E0    = 5'd12;
  localparam logic [4:0] ST_E1    = 5'd13;
  localparam logic [4:0] ST_E2    = 5'd14;
  localparam logic [4:0] ST_B0    = 5'd15;
  localparam logic [4:0] ST_B1    = 5'd16;

  logic [4:0] state;

  logic [2:0] act;
  logic [4:0] len_in, l_sat;
  logic [7:0] byte_in;
  logic       accept;

  logic [4:0] l_q;
  logic       last_q, hf_last, d_ret, is_end;
  logic [7:0] byte_q;
  logic [4:0] hval;
  logic [8:0] hcount, idx, rcount;
  logic [7:0] rsym;
  logic       ractive;

  logic [22:0] acc, acc_push;
  logic [4:0]  fill;
  logic [7:0]  hbyte, dbyte;
  logic        hvalid;
  logic [3:0]  ecnt;
  logic        pk_rdy, ofree, drain;

  logic        push_en;
  logic [15:0] push_val;
  logic [4:0]  push_len;

  logic [chre_pkg::ENTRY_W-1:0] mem [chre_pkg::SYMBOL_COUNT];
  logic [chre_pkg::ENTRY_W-1:0] rd_q, wdata;
  logic [chre_pkg::SYM_W-1:0]   raddr, waddr;
  logic                         ren, wen;
  logic [4:0]                   rlen;
  logic [15:0]                  rcode;

  logic [4:0]  blvl, blvl_q, blast;
  logic [8:0]  baddr, baddr_q;
  logic        bvld, started, bmatch, bzero;
  logic [15:0] bcode, nc;

  logic [13:0] rprod;
  logic        rep;
  logic        ext_h, ext_d;

  assign act     = s_tdata[2:0];
  assign len_in  = s_tdata[7:3];
  assign byte_in = s_tdata[15:8];
  assign l_sat   = (len_in > 5'(chre_pkg::MAX_CODE_LENGTH)) ?
                   5'(chre_pkg::MAX_CODE_LENGTH) : len_in;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign rlen  = rd_q[chre_pkg::ENTRY_W-1:chre_pkg::CODE_W];
  assign rcode = rd_q[chre_pkg::CODE_W-1:0];
  assign rprod = (rcount - 9'd1) * rlen;
  assign rep   = (rcount >= 9'd3) && (rprod > 14'(chre_pkg::MAX_CODE_LENGTH));

  assign ext_h = (hcount != 9'd0) && (l_sat == hval) &&
                 (hcount < 9'(chre_pkg::RUN_LIMIT));
  assign ext_d = ractive && (byte_in == rsym) && (rcount < 9'(chre_pkg::RUN_LIMIT));

  assign pk_rdy = (fill < 5'd8);
  assign ofree  = !m_tvalid || m_tready;
  assign drain  = !pk_rdy && ((ecnt == 4'(chre_pkg::MAX_OUT)) || !hvalid || ofree);
  assign dbyte  = 8'(acc >> (fill - 5'd8));
  assign acc_push = (acc << push_len) |
                    (23'(push_val) & ((23'd1 << push_len) - 23'd1));

  assign bmatch = bvld && (rlen == blvl_q);
  assign bzero  = bvld && (rlen == 5'd0) && (blvl_q == 5'd1);
  assign nc = !started ? 16'd0 :
              (blast != blvl_q) ? 16'((bcode + 16'd1) << (blvl_q - blast)) :
              bcode + 16'd1;

  always_comb begin
    push_en  = 1'b0;
    push_val = '0;
    push_len = '0;
    ren      = 1'b0;
    raddr    = '0;
    unique case (state)
      ST_HF0: begin
        if (pk_rdy && hcount != 9'd0) begin
          push_en  = 1'b1;
          push_val = 16'(hval);
          push_len = 5'd5;
        end
      end
      ST_HF1: begin
        push_en  = pk_rdy;
        push_val = 16'(HDR_TAG + 5'(chre_pkg::cnt_class(hcount)));
        push_len = 5'd5;
      end
      ST_HF2: begin
        push_en  = pk_rdy;
        push_val = chre_pkg::cnt_bits(hcount);
        push_len = chre_pkg::cnt_len(chre_pkg::cnt_class(hcount));
      end
      ST_DF0: begin
        ren   = ractive;
        raddr = {1'b0, rsym};
      end
      ST_DF1: begin
        if (rep && pk_rdy) begin
          push_en  = 1'b1;
          push_val = rcode;
          push_len = rlen;
          ren      = 1'b1;
          raddr    = chre_pkg::REPEAT_BASE + 9'(chre_pkg::cnt_class(rcount));
        end
      end
      ST_DF2, ST_DF4, ST_E1: begin
        push_en  = pk_rdy;
        push_val = rcode;
        push_len = rlen;
      end
      ST_DF3: begin
        push_en  = pk_rdy;
        push_val = chre_pkg::cnt_bits(rcount);
        push_len = chre_pkg::cnt_len(chre_pkg::cnt_class(rcount));
      end
      ST_E0: begin
        ren   = 1'b1;
        raddr = chre_pkg::END_SYMBOL;
      end
      ST_E2: begin
        push_en  = pk_rdy && (fill != 5'd0);
        push_len = 5'd8 - fill;
      end
      ST_B0: begin
        ren   = 1'b1;
        raddr = baddr;
      end
      default: begin
      end
    endcase
  end

  localparam logic [4:0] HDR_TAG = chre_pkg::HDR_TAG_BASE;

  always_comb begin
    wen   = 1'b0;
    waddr = '0;
    wdata = '0;
    if (accept && act == chre_pkg::A_LOAD && idx < 9'(chre_pkg::SYMBOL_COUNT)) begin
      wen   = 1'b1;
      waddr = idx;
      wdata = {l_sat, 16'd0};
    end else if (bmatch) begin
      wen   = 1'b1;
      waddr = baddr_q;
      wdata = {rlen, nc};
    end else if (bzero) begin
      wen   = 1'b1;
      waddr = baddr_q;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      hval     <= '0;
      hcount   <= '0;
      idx      <= '0;
      rsym     <= '0;
      rcount   <= '0;
      ractive  <= 1'b0;
      acc      <= '0;
      fill     <= '0;
      hvalid   <= 1'b0;
      ecnt     <= '0;
      m_tvalid <= 1'b0;
      bvld     <= 1'b0;
      started  <= 1'b0;
      is_end   <= 1'b0;
    end else begin
      bvld <= (state == ST_B0);
      if (bmatch) begin
        bcode   <= nc;
        blast   <= blvl_q;
        started <= 1'b1;
      end

      if (accept && act == chre_pkg::A_START) begin
        acc  <= 23'(chre_pkg::MAGIC);
        fill <= 5'd16;
      end else if (push_en) begin
        acc  <= acc_push;
        fill <= fill + push_len;
      end else if (drain) begin
        fill <= fill - 5'd8;
      end

      if (drain && ecnt != 4'(chre_pkg::MAX_OUT)) begin
        ecnt   <= ecnt + 4'd1;
        hbyte  <= dbyte;
        hvalid <= 1'b1;
      end

      if (drain && ecnt != 4'(chre_pkg::MAX_OUT) && hvalid) begin
        m_tvalid <= 1'b1;
        m_tdata  <= hbyte;
        m_tlast  <= 1'b0;
        m_tuser  <= 1'b0;
      end else if (state == ST_FIN && pk_rdy && hvalid && ofree) begin
        m_tvalid <= 1'b1;
        m_tdata  <= hbyte;
        m_tlast  <= 1'b1;
        m_tuser  <= is_end;
        hvalid   <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            ecnt   <= '0;
            is_end <= 1'b0;
            byte_q <= byte_in;
            unique case (act)
              chre_pkg::A_START: begin
                hval    <= '0;
                hcount  <= '0;
                idx     <= '0;
                ractive <= 1'b0;
                rcount  <= '0;
                rsym    <= '0;
                state   <= ST_FIN;
              end
              chre_pkg::A_LOAD: begin
                if (idx < 9'(chre_pkg::SYMBOL_COUNT)) begin
                  idx    <= idx + 9'd1;
                  l_q    <= l_sat;
                  last_q <= (idx == 9'(chre_pkg::SYMBOL_COUNT - 1));
                  if (ext_h) begin
                    hcount <= hcount + 9'd1;
                    if (idx == 9'(chre_pkg::SYMBOL_COUNT - 1)) begin
                      hf_last <= 1'b1;
                      state   <= ST_HF0;
                    end else begin
                      state <= ST_FIN;
                    end
                  end else begin
                    hf_last <= 1'b0;
                    state   <= ST_HF0;
                  end
                end else begin
                  state <= ST_FIN;
                end
              end
              chre_pkg::A_BUILD: begin
                blvl    <= 5'd1;
                baddr   <= '0;
                started <= 1'b0;
                state   <= ST_B0;
              end
              chre_pkg::A_DATA: begin
                if (ext_d) begin
                  rcount <= rcount + 9'd1;
                  state  <= ST_FIN;
                end else begin
                  d_ret <= 1'b0;
                  state <= ST_DF0;
                end
              end
              chre_pkg::A_END: begin
                d_ret <= 1'b1;
                state <= ST_DF0;
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_FIN: begin
          if (pk_rdy && (!hvalid || ofree)) begin
            state <= ST_IDLE;
          end
        end
        ST_HF0: begin
          if (pk_rdy) begin
            if (hcount >= 9'd3) begin
              state <= ST_HF1;
            end else if (hcount != 9'd0) begin
              hcount <= hcount - 9'd1;
            end else begin
              state <= hf_last ? ST_FIN : ST_LPOST;
            end
          end
        end
        ST_HF1: begin
          if (pk_rdy) state <= ST_HF2;
        end
        ST_HF2: begin
          if (pk_rdy) begin
            hcount <= '0;
            state  <= hf_last ? ST_FIN : ST_LPOST;
          end
        end
        ST_LPOST: begin
          hval   <= l_q;
          hcount <= 9'd1;
          if (last_q) begin
            hf_last <= 1'b1;
            state   <= ST_HF0;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_DF0: begin
          state <= ractive ? ST_DF1 : ST_DPOST;
        end
        ST_DF1: begin
          if (rep) begin
            if (pk_rdy) state <= ST_DF2;
          end else if (rlen == 5'd0) begin
            state <= ST_DPOST;
          end else begin
            state <= ST_DF4;
          end
        end
        ST_DF2: begin
          if (pk_rdy) state <= ST_DF3;
        end
        ST_DF3: begin
          if (pk_rdy) state <= ST_DPOST;
        end
        ST_DF4: begin
          if (pk_rdy) begin
            if (rcount == 9'd1) state <= ST_DPOST;
            else rcount <= rcount - 9'd1;
          end
        end
        ST_DPOST: begin
          if (!d_ret) begin
            rsym    <= byte_q;
            rcount  <= 9'd1;
            ractive <= 1'b1;
            state   <= ST_FIN;
          end else begin
            rcount  <= '0;
            ractive <= 1'b0;
            state   <= ST_E0;
          end
        end
        ST_E0: state <= ST_E1;
        ST_E1: begin
          if (pk_rdy) state <= ST_E2;
        end
        ST_E2: begin
          if (pk_rdy) begin
            is_end <= 1'b1;
            state  <= ST_FIN;
          end
        end
        ST_B0: begin
          blvl_q  <= blvl;
          baddr_q <= baddr;
          if (baddr == 9'(chre_pkg::SYMBOL_COUNT - 1)) begin
            baddr <= '0;
            if (blvl == 5'(chre_pkg::MAX_CODE_LENGTH)) state <= ST_B1;
            else blvl <= blvl + 5'd1;
          end else begin
            baddr <= baddr + 9'd1;
          end
        end
        ST_B1: state <= ST_FIN;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/chre_checker.sv */
module chre_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid after reset");

  a_sd_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("stream end beat without item end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready straight after an accepted beat");

endmodule

bind canonical_huffman_rle_encoder_core chre_checker u_chre_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
